### rtl/core/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants, angle table and flag type of the Cartesian to spherical
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_COORD_WIDTH       = 16;
	localparam int DEF_CORDIC_ITERATIONS = 18;

	// Output field widths
	localparam int RADIUS_BITS = 16;
	localparam int POLAR_BITS  = 16;
	localparam int AZIM_BITS   = 18;
	localparam int RADIUS_MAX  = 65535;

	// Angles in degrees times 256
	localparam int RIGHT_ANGLE    = 23040;
	localparam int STRAIGHT_ANGLE = 46080;

	// CORDIC scaling: components times 2^28, accumulator in degrees times 2^16
	localparam int GUARD_SHIFT = 28;
	localparam int ACC_BITS    = 25;
	localparam int ANGLE_BITS  = 16;
	localparam int ACC_FRAC    = 8;

	// Normalization for the polar angle: operand width, window and shift limit.
	// The operand is wide enough for the unshifted xy sum of the widest
	// coordinates; the window bounds the larger square after shifting.
	localparam int NORM_BITS      = 64;
	localparam int NORM_WINDOW    = 62;
	localparam int NORM_ROOT_BITS = NORM_BITS / 2;
	localparam int NORM_STEPS     = 5;
	localparam int NORM_K_BITS    = NORM_STEPS;
	localparam int MAX_NORM_SHIFT = 30;

	// Front-end latency (input, squares, sums)
	localparam int FRONT_STAGES = 3;

	// atan(2^-i) in degrees times 65536
	localparam int ATAN_TABLE [32] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0
	};

	// Sign and zero information that selects the special cases
	typedef struct packed {
		logic zero_vec;
		logic x_zero;
		logic x_neg;
		logic y_pos;
		logic y_neg;
		logic sxy_zero;
		logic z_zero;
		logic z_pos;
	} flags_t;

endpackage

`default_nettype wire

### rtl/core/c2s_delay.sv
// ----------------------------------------------------------------------------
// c2s_delay
// Enable-gated register line that keeps side data aligned with the
// longer arithmetic paths.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  wire              clk,
	input  wire              en,
	input  wire [WIDTH-1:0]  d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// Shift one place per advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

`default_nettype wire

### rtl/core/c2s_front.sv
// ----------------------------------------------------------------------------
// c2s_front
// Input register, component squares and sums, sign flags and CORDIC
// operands for the azimuth. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_front #(
	parameter int COORD_WIDTH = c2s_pkg::DEF_COORD_WIDTH
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire signed [COORD_WIDTH-1:0] x,
	input  wire signed [COORD_WIDTH-1:0] y,
	input  wire signed [COORD_WIDTH-1:0] z,
	output c2s_pkg::flags_t              flags,
	output logic [2*COORD_WIDTH-1:0]     total,
	output logic [2*COORD_WIDTH-1:0]     sxy,
	output logic [2*COORD_WIDTH-1:0]     mag_max,
	output logic [COORD_WIDTH-1:0]       z_abs,
	output logic signed [COORD_WIDTH:0]  az_a,
	output logic signed [COORD_WIDTH:0]  az_b
);

	import c2s_pkg::*;

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] x_s1, y_s1, z_s1;

	logic signed [2*W-1:0] xsq, ysq, zsq;
	logic signed [W:0]     xe, ye, ze, zneg;
	flags_t                flg;

	logic [2*W-1:0]    xx_s2, yy_s2, zz_s2;
	logic [W-1:0]      za_s2;
	logic signed [W:0] aa_s2, ab_s2;
	flags_t            flags_s2;

	logic [2*W-1:0] sum_xy;

	logic [2*W-1:0]    total_s3, sxy_s3, max_s3;
	logic [W-1:0]      za_s3;
	logic signed [W:0] aa_s3, ab_s3;
	flags_t            flags_s3;

	// Capture the request
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			y_s1 <= y;
			z_s1 <= z;
		end
	end

	// Squares, magnitudes and signs
	assign xsq  = x_s1 * x_s1;
	assign ysq  = y_s1 * y_s1;
	assign zsq  = z_s1 * z_s1;
	assign xe   = (W+1)'(x_s1);
	assign ye   = (W+1)'(y_s1);
	assign ze   = (W+1)'(z_s1);
	assign zneg = -ze;

	always_comb begin
		flg.x_zero   = (x_s1 == '0);
		flg.x_neg    = x_s1[W-1];
		flg.y_neg    = y_s1[W-1];
		flg.y_pos    = !y_s1[W-1] && (y_s1 != '0);
		flg.z_zero   = (z_s1 == '0);
		flg.z_pos    = !z_s1[W-1] && (z_s1 != '0);
		flg.sxy_zero = (x_s1 == '0) && (y_s1 == '0);
		flg.zero_vec = (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2    <= unsigned'(xsq);
			yy_s2    <= unsigned'(ysq);
			zz_s2    <= unsigned'(zsq);
			za_s2    <= z_s1[W-1] ? zneg[W-1:0] : ze[W-1:0];
			aa_s2    <= x_s1[W-1] ? -xe : xe;
			ab_s2    <= x_s1[W-1] ? -ye : ye;
			flags_s2 <= flg;
		end
	end

	// Sums and the larger of the two parts for normalization
	assign sum_xy = xx_s2 + yy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s3   <= sum_xy;
			total_s3 <= sum_xy + zz_s2;
			max_s3   <= (sum_xy > zz_s2) ? sum_xy : zz_s2;
			za_s3    <= za_s2;
			aa_s3    <= aa_s2;
			ab_s3    <= ab_s2;
			flags_s3 <= flags_s2;
		end
	end

	assign flags   = flags_s3;
	assign total   = total_s3;
	assign sxy     = sxy_s3;
	assign mag_max = max_s3;
	assign z_abs   = za_s3;
	assign az_a    = aa_s3;
	assign az_b    = ab_s3;

endmodule

`default_nettype wire

### rtl/core/c2s_norm.sv
// ----------------------------------------------------------------------------
// c2s_norm
// Pipelined normalizer: shifts the xy sum by 4^k and |z| by 2^k, with k the
// largest value up to the limit that keeps the larger square in the window.
// One binary shift step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_norm #(
	parameter int COORD_WIDTH = c2s_pkg::DEF_COORD_WIDTH
) (
	input  wire                                 clk,
	input  wire                                 en,
	input  wire [2*COORD_WIDTH-1:0]             mag_max,
	input  wire [2*COORD_WIDTH-1:0]             sxy,
	input  wire [COORD_WIDTH-1:0]               z_abs,
	output logic [c2s_pkg::NORM_BITS-1:0]       sxy_norm,
	output logic [c2s_pkg::NORM_ROOT_BITS-1:0]  z_norm
);

	import c2s_pkg::*;

	logic [NORM_BITS-1:0]      m_s  [NORM_STEPS];
	logic [NORM_BITS-1:0]      n_s  [NORM_STEPS];
	logic [NORM_ROOT_BITS-1:0] zn_s [NORM_STEPS];
	logic [NORM_K_BITS-1:0]    k_s  [NORM_STEPS];

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_step
		localparam int S = 1 << (NORM_STEPS - 1 - j);

		logic [NORM_BITS-1:0]      m_prev, n_prev;
		logic [NORM_ROOT_BITS-1:0] zn_prev;
		logic [NORM_K_BITS-1:0]    k_prev;
		logic                      take;

		if (j == 0) begin : g_first
			assign m_prev  = NORM_BITS'(mag_max);
			assign n_prev  = NORM_BITS'(sxy);
			assign zn_prev = NORM_ROOT_BITS'(z_abs);
			assign k_prev  = '0;
		end else begin : g_next
			assign m_prev  = m_s[j-1];
			assign n_prev  = n_s[j-1];
			assign zn_prev = zn_s[j-1];
			assign k_prev  = k_s[j-1];
		end

		// Take the step when the shifted value stays in the window and the
		// limit allows it
		assign take = ((m_prev >> (NORM_WINDOW - 2*S)) == '0)
			&& (({1'b0, k_prev} + (NORM_K_BITS+1)'(S))
				<= (NORM_K_BITS+1)'(MAX_NORM_SHIFT));

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					m_s[j]  <= m_prev << (2*S);
					n_s[j]  <= n_prev << (2*S);
					zn_s[j] <= zn_prev << S;
					k_s[j]  <= k_prev + NORM_K_BITS'(S);
				end else begin
					m_s[j]  <= m_prev;
					n_s[j]  <= n_prev;
					zn_s[j] <= zn_prev;
					k_s[j]  <= k_prev;
				end
			end
		end
	end

	assign sxy_norm = n_s[NORM_STEPS-1];
	assign z_norm   = zn_s[NORM_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/c2s_sqrt.sv
// ----------------------------------------------------------------------------
// c2s_sqrt
// Pipelined integer square root, one root bit per stage, restoring form.
// Gives the floor root and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt #(
	parameter int IN_BITS = 32
) (
	input  wire                    clk,
	input  wire                    en,
	input  wire [IN_BITS-1:0]      n,
	output logic [IN_BITS/2-1:0]   root,
	output logic [IN_BITS-1:0]     rem
);

	localparam int R = IN_BITS / 2;

	logic [IN_BITS-1:0] rem_s  [R];
	logic [R-1:0]       root_s [R];

	for (genvar j = 0; j < R; j++) begin : g_bit
		localparam int B = R - 1 - j;

		logic [IN_BITS-1:0] rem_prev, trial;
		logic [R-1:0]       root_prev;

		if (j == 0) begin : g_first
			assign rem_prev  = n;
			assign root_prev = '0;
		end else begin : g_next
			assign rem_prev  = rem_s[j-1];
			assign root_prev = root_s[j-1];
		end

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 4^B
		assign trial = (IN_BITS'(root_prev) << (B + 1)) | (IN_BITS'(1) << (2*B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_prev >= trial) begin
					rem_s[j]  <= rem_prev - trial;
					root_s[j] <= root_prev | (R'(1) << B);
				end else begin
					rem_s[j]  <= rem_prev;
					root_s[j] <= root_prev;
				end
			end
		end
	end

	assign root = root_s[R-1];
	assign rem  = rem_s[R-1];

endmodule

`default_nettype wire

### rtl/core/c2s_cordic.sv
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined vectoring CORDIC: atan(b/a) for a >= 0 in degrees times 256,
// rounded and clamped to a right angle. One rotation per stage, then a
// rounding stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic #(
	parameter int IN_BITS           = 17,
	parameter int CORDIC_ITERATIONS = c2s_pkg::DEF_CORDIC_ITERATIONS
) (
	input  wire                                   clk,
	input  wire                                   en,
	input  wire signed [IN_BITS-1:0]              a,
	input  wire signed [IN_BITS-1:0]              b,
	output logic signed [c2s_pkg::ANGLE_BITS-1:0] angle
);

	import c2s_pkg::*;

	localparam int N  = CORDIC_ITERATIONS;
	localparam int DW = IN_BITS + GUARD_SHIFT + 2;

	logic signed [DW-1:0]       px_s  [N];
	logic signed [DW-1:0]       py_s  [N];
	logic signed [ACC_BITS-1:0] acc_s [N];

	logic signed [ACC_BITS-1:0]   rnd;
	logic signed [ANGLE_BITS-1:0] angle_s;

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [DW-1:0]       px_prev, py_prev, dx, dy;
		logic signed [ACC_BITS-1:0] acc_prev, step;

		if (i == 0) begin : g_first
			assign px_prev  = DW'(a) <<< GUARD_SHIFT;
			assign py_prev  = DW'(b) <<< GUARD_SHIFT;
			assign acc_prev = '0;
		end else begin : g_next
			assign px_prev  = px_s[i-1];
			assign py_prev  = py_s[i-1];
			assign acc_prev = acc_s[i-1];
		end

		assign dx   = py_prev >>> i;
		assign dy   = px_prev >>> i;
		assign step = ACC_BITS'(ATAN_TABLE[i]);

		// Rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				if (!py_prev[DW-1]) begin
					px_s[i]  <= px_prev + dx;
					py_s[i]  <= py_prev - dy;
					acc_s[i] <= acc_prev + step;
				end else begin
					px_s[i]  <= px_prev - dx;
					py_s[i]  <= py_prev + dy;
					acc_s[i] <= acc_prev - step;
				end
			end
		end
	end

	// Round to degrees times 256, ties up, and clamp
	assign rnd = (acc_s[N-1] + ACC_BITS'(1 << (ACC_FRAC - 1))) >>> ACC_FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (rnd > ACC_BITS'(RIGHT_ANGLE)) begin
				angle_s <= ANGLE_BITS'(RIGHT_ANGLE);
			end else if (rnd < -ACC_BITS'(RIGHT_ANGLE)) begin
				angle_s <= -ANGLE_BITS'(RIGHT_ANGLE);
			end else begin
				angle_s <= rnd[ANGLE_BITS-1:0];
			end
		end
	end

	assign angle = angle_s;

endmodule

`default_nettype wire

### rtl/core/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts one signed 3-D integer vector to radius, polar angle and azimuth
// (degrees times 256), with a flag for the zero vector.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   input    in         in_valid, in_stall  coord_x, coord_y, coord_z
//   output   out        out_valid, out_stall radius, polar_angle, azimuth,
//                                           zero_vector
//
// One request per clock while no stalled result holds the pipeline. The
// polar path sets the latency: 3 front stages, 5 normalizer stages, a 32-stage
// square root, the CORDIC rotations plus rounding, and the output register.
// Reset clears only the valid bits; the datapath carries no reset.
// A waiting result with out_stall high holds the whole pipeline and raises
// in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical #(
	parameter int COORD_WIDTH       = c2s_pkg::DEF_COORD_WIDTH,
	parameter int CORDIC_ITERATIONS = c2s_pkg::DEF_CORDIC_ITERATIONS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [COORD_WIDTH-1:0]         coord_x,
	input  wire signed [COORD_WIDTH-1:0]         coord_y,
	input  wire signed [COORD_WIDTH-1:0]         coord_z,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [c2s_pkg::RADIUS_BITS-1:0]      radius,
	output logic [c2s_pkg::POLAR_BITS-1:0]       polar_angle,
	output logic signed [c2s_pkg::AZIM_BITS-1:0] azimuth,
	output logic                                 zero_vector
);

	import c2s_pkg::*;

	localparam int W       = COORD_WIDTH;
	localparam int N       = CORDIC_ITERATIONS;
	localparam int RHO_LAT = NORM_STEPS + NORM_ROOT_BITS;
	localparam int POL_LAT = RHO_LAT + N + 1;
	localparam int RAD_DLY = POL_LAT - W;
	localparam int VLD_LEN = FRONT_STAGES + POL_LAT + 1;
	localparam int FLG_W   = $bits(flags_t);
	localparam int RC      = (W + 1 > RADIUS_BITS + 1) ? W + 1 : RADIUS_BITS + 1;
	localparam int POL_AW  = NORM_ROOT_BITS + 1;

	logic advance;

	logic                  vld_q [VLD_LEN];

	flags_t                fr_flags;
	logic [2*W-1:0]        fr_total, fr_sxy, fr_max;
	logic [W-1:0]          fr_zabs;
	logic signed [W:0]     fr_aa, fr_ab;

	logic [NORM_BITS-1:0]      sxy_norm;
	logic [NORM_ROOT_BITS-1:0] z_norm, z_norm_d, rho;
	logic [NORM_BITS-1:0]      rho_rem;

	logic signed [ANGLE_BITS-1:0] pol_atan, az_atan, az_atan_d;

	logic [W-1:0]     rad_root, rad_root_d;
	logic [2*W-1:0]   rad_rem, rad_rem_d;
	logic [FLG_W-1:0] flags_bits_d;
	flags_t           flg;

	logic [W:0]                 rad_up;
	logic [RC-1:0]              rad_ext;
	logic signed [AZIM_BITS-1:0] pa, aa, pol_val, az_val;

	logic [RADIUS_BITS-1:0]      radius_q;
	logic [POLAR_BITS-1:0]       polar_q;
	logic signed [AZIM_BITS-1:0] azim_q;
	logic                        zero_q;

	// Advance everything unless a result waits and is stalled
	assign advance  = !(vld_q[VLD_LEN-1] && out_stall);
	assign in_stall = !advance;

	// Valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLD_LEN; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (advance) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < VLD_LEN; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	c2s_front #(.COORD_WIDTH(W)) u_front (
		.clk     (clk),
		.en      (advance),
		.x       (coord_x),
		.y       (coord_y),
		.z       (coord_z),
		.flags   (fr_flags),
		.total   (fr_total),
		.sxy     (fr_sxy),
		.mag_max (fr_max),
		.z_abs   (fr_zabs),
		.az_a    (fr_aa),
		.az_b    (fr_ab)
	);

	// Polar path: normalize, root of the xy part, then atan(rho / z)
	c2s_norm #(.COORD_WIDTH(W)) u_norm (
		.clk      (clk),
		.en       (advance),
		.mag_max  (fr_max),
		.sxy      (fr_sxy),
		.z_abs    (fr_zabs),
		.sxy_norm (sxy_norm),
		.z_norm   (z_norm)
	);

	c2s_sqrt #(.IN_BITS(NORM_BITS)) u_rho_sqrt (
		.clk  (clk),
		.en   (advance),
		.n    (sxy_norm),
		.root (rho),
		.rem  (rho_rem)
	);

	c2s_delay #(.WIDTH(NORM_ROOT_BITS), .DEPTH(NORM_ROOT_BITS)) u_z_dly (
		.clk (clk),
		.en  (advance),
		.d   (z_norm),
		.q   (z_norm_d)
	);

	c2s_cordic #(.IN_BITS(POL_AW), .CORDIC_ITERATIONS(N)) u_pol_cordic (
		.clk   (clk),
		.en    (advance),
		.a     (signed'({1'b0, z_norm_d})),
		.b     (signed'({1'b0, rho})),
		.angle (pol_atan)
	);

	// Azimuth path
	c2s_cordic #(.IN_BITS(W + 1), .CORDIC_ITERATIONS(N)) u_az_cordic (
		.clk   (clk),
		.en    (advance),
		.a     (fr_aa),
		.b     (fr_ab),
		.angle (az_atan)
	);

	c2s_delay #(.WIDTH(ANGLE_BITS), .DEPTH(RHO_LAT)) u_az_dly (
		.clk (clk),
		.en  (advance),
		.d   (az_atan),
		.q   (az_atan_d)
	);

	// Radius path
	c2s_sqrt #(.IN_BITS(2 * W)) u_rad_sqrt (
		.clk  (clk),
		.en   (advance),
		.n    (fr_total),
		.root (rad_root),
		.rem  (rad_rem)
	);

	c2s_delay #(.WIDTH(3 * W), .DEPTH(RAD_DLY)) u_rad_dly (
		.clk (clk),
		.en  (advance),
		.d   ({rad_root, rad_rem}),
		.q   ({rad_root_d, rad_rem_d})
	);

	c2s_delay #(.WIDTH(FLG_W), .DEPTH(POL_LAT)) u_flg_dly (
		.clk (clk),
		.en  (advance),
		.d   (fr_flags),
		.q   (flags_bits_d)
	);

	assign flg = flags_t'(flags_bits_d);

	// Round the radius to nearest and saturate
	assign rad_up  = (W+1)'(rad_root_d) + (W+1)'(rad_rem_d > (2*W)'(rad_root_d));
	assign rad_ext = RC'(rad_up);

	// Pick the special cases and fold the quadrants
	assign pa = AZIM_BITS'(pol_atan);
	assign aa = AZIM_BITS'(az_atan_d);

	always_comb begin
		priority if (flg.zero_vec) begin
			pol_val = '0;
		end else if (flg.sxy_zero) begin
			pol_val = flg.z_pos ? '0 : AZIM_BITS'(STRAIGHT_ANGLE);
		end else if (flg.z_zero) begin
			pol_val = AZIM_BITS'(RIGHT_ANGLE);
		end else if (flg.z_pos) begin
			pol_val = pa;
		end else begin
			pol_val = AZIM_BITS'(STRAIGHT_ANGLE) - pa;
		end
		if (pol_val[AZIM_BITS-1]) begin
			pol_val = '0;
		end

		priority if (flg.zero_vec) begin
			az_val = '0;
		end else if (flg.x_zero) begin
			priority if (flg.y_pos) begin
				az_val = AZIM_BITS'(RIGHT_ANGLE);
			end else if (flg.y_neg) begin
				az_val = -AZIM_BITS'(RIGHT_ANGLE);
			end else begin
				az_val = '0;
			end
		end else if (flg.x_neg) begin
			az_val = aa + AZIM_BITS'(STRAIGHT_ANGLE);
		end else begin
			az_val = aa;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance) begin
			radius_q <= (rad_ext > RC'(RADIUS_MAX)) ? '1 : rad_ext[RADIUS_BITS-1:0];
			polar_q  <= pol_val[POLAR_BITS-1:0];
			azim_q   <= az_val;
			zero_q   <= flg.zero_vec;
		end
	end

	assign out_valid   = vld_q[VLD_LEN-1];
	assign radius      = radius_q;
	assign polar_angle = polar_q;
	assign azimuth     = azim_q;
	assign zero_vector = zero_q;

endmodule

`default_nettype wire

### tb/c2s_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c2s_checker
// Watches both channels of the Cartesian to spherical converter, computes
// the expected radius and angles for every accepted request and compares
// them field by field with the results in arrival order.
// ----------------------------------------------------------------------------

module c2s_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire signed [15:0] coord_x,
	input  wire signed [15:0] coord_y,
	input  wire signed [15:0] coord_z,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire [15:0]        radius,
	input  wire [15:0]        polar_angle,
	input  wire signed [17:0] azimuth,
	input  wire               zero_vector,
	output int                fail_count,
	output int                pending_count
);
	import c2s_pkg::*;

	typedef struct packed {
		logic [15:0]        radius;
		logic [15:0]        polar;
		logic signed [17:0] azim;
		logic               zero;
	} sph_t;

	sph_t expected_q[$];

	// Bit-serial integer square root, floor
	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Vectoring rotations giving atan(b/a), a >= 0, degrees times 256
	function automatic longint vector_angle(longint a, longint b);
		longint px, py, acc, dx, dy;
		px = a <<< GUARD_SHIFT;
		py = b <<< GUARD_SHIFT;
		acc = 0;
		for (int i = 0; i < DEF_CORDIC_ITERATIONS && i < 32; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py >= 0) begin
				px += dx;
				py -= dy;
				acc += ATAN_TABLE[i];
			end else begin
				px -= dx;
				py += dy;
				acc -= ATAN_TABLE[i];
			end
		end
		acc = (acc + 128) >>> 8;
		if (acc > RIGHT_ANGLE) acc = RIGHT_ANGLE;
		if (acc < -RIGHT_ANGLE) acc = -RIGHT_ANGLE;
		return acc;
	endfunction

	function automatic sph_t to_spherical(longint x, longint y, longint z);
		sph_t r;
		longint unsigned sxy, zz, total, root, m;
		longint polar, azim, rho, zk;
		int k;
		sxy = x * x + y * y;
		zz = z * z;
		total = sxy + zz;
		root = floor_sqrt(total);
		if (total - root * root > root) root++;
		if (root > RADIUS_MAX) root = RADIUS_MAX;
		r = '0;
		if (total == 0) begin
			r.zero = 1'b1;
			return r;
		end
		// azimuth, with the x zero axis handled apart
		if (x == 0) azim = (y > 0) ? RIGHT_ANGLE : ((y < 0) ? -RIGHT_ANGLE : 0);
		else if (x > 0) azim = vector_angle(x, y);
		else azim = vector_angle(-x, -y) + STRAIGHT_ANGLE;
		// polar angle, with the z axis and the xy plane handled apart
		if (sxy == 0) begin
			polar = (z > 0) ? 0 : STRAIGHT_ANGLE;
		end else if (z == 0) begin
			polar = RIGHT_ANGLE;
		end else begin
			m = (sxy > zz) ? sxy : zz;
			k = 0;
			while (k < MAX_NORM_SHIFT && (m >> (60 - 2 * k)) == 0) k++;
			rho = floor_sqrt(sxy << (2 * k));
			zk = z <<< k;
			if (zk > 0) polar = vector_angle(zk, rho);
			else polar = STRAIGHT_ANGLE - vector_angle(-zk, rho);
			if (polar < 0) polar = 0;
		end
		r.radius = root[15:0];
		r.polar = polar[15:0];
		r.azim = azim[17:0];
		return r;
	endfunction

	assign pending_count = expected_q.size();

	// Predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		sph_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(to_spherical(coord_x, coord_y, coord_z));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result r=%0d p=%0d a=%0d z=%0d", $time,
						radius, polar_angle, azimuth, zero_vector);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.radius !== radius || e.polar !== polar_angle ||
							e.azim !== azimuth || e.zero !== zero_vector) begin
						$display("%0t: mismatch expected r=%0d p=%0d a=%0d z=%0d", $time,
							e.radius, e.polar, e.azim, e.zero);
						$display("%0t:          actual   r=%0d p=%0d a=%0d z=%0d", $time,
							radius, polar_angle, azimuth, zero_vector);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb_cartesian_to_spherical.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical
// Drives directed and random vectors into the converter with random idle
// bursts on both channels and one long output hold-off, then gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb_cartesian_to_spherical;
	localparam int N_RANDOM = 1330;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic signed [15:0] coord_x, coord_y, coord_z;
	logic out_stall;
	wire in_stall, out_valid, zero_vector;
	wire [15:0] radius, polar_angle;
	wire signed [17:0] azimuth;
	int fail_count, pending_count;
	bit quiet_phase;
	bit hold_done;
	int idle_cycles = 0;

	cartesian_to_spherical dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.radius(radius), .polar_angle(polar_angle),
		.azimuth(azimuth), .zero_vector(zero_vector)
	);

	c2s_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.radius(radius), .polar_angle(polar_angle),
		.azimuth(azimuth), .zero_vector(zero_vector),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random coordinate: uniform half the time, otherwise extreme or small
	function automatic logic [15:0] pick_coord();
		unique case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Output side: random stall bursts, one long hold-off
	initial begin
		int burst;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		repeat (200) @(posedge clk);
		out_stall <= 1'b1;
		repeat (150) @(posedge clk);
		out_stall <= 1'b0;
		hold_done = 1'b1;
		forever begin
			@(posedge clk);
			if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 5);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [15:0] dir_vec[$][3];
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		quiet_phase = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vector, axes, extremes, sign combinations
		dir_vec = '{
			'{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0005, 16'h0000},
			'{16'h0000, 16'hfffb, 16'h0000}, '{16'h0000, 16'h0000, 16'h0007},
			'{16'h0000, 16'h0000, 16'hfff9}, '{16'h0003, 16'h0000, 16'h0000},
			'{16'hfffd, 16'h0000, 16'h0000}, '{16'h7fff, 16'h7fff, 16'h7fff},
			'{16'h8000, 16'h8000, 16'h8000}, '{16'h8000, 16'h7fff, 16'h0000},
			'{16'h7fff, 16'h8000, 16'h0001}, '{16'h0000, 16'h8000, 16'h7fff},
			'{16'h0000, 16'h0000, 16'h8000}, '{16'h0001, 16'h0001, 16'h0001},
			'{16'hffff, 16'hffff, 16'hffff}, '{16'hffff, 16'h0001, 16'hffff},
			'{16'h0001, 16'hffff, 16'h0000}, '{16'h0003, 16'h0004, 16'h0000},
			'{16'hfffd, 16'h0004, 16'h000c}, '{16'h0000, 16'h0001, 16'h8000},
			'{16'h5555, 16'haaaa, 16'h1234}, '{16'haaaa, 16'h5555, 16'hedcb}
		};
		foreach (dir_vec[i]) send_request(dir_vec[i][0], dir_vec[i][1], dir_vec[i][2]);

		// Random vectors; the last stretch runs without idling
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n >= N_RANDOM - 150 && hold_done) quiet_phase = 1'b1;
			send_request(pick_coord(), pick_coord(), pick_coord());
		end
		in_valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
